// ----- sv/sfe_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sfe_pkg: shared definitions for the escaped SPI frame exchanger
// Framing bytes, length offset, default buffer size and action codes.
// ----------------------------------------------------------------------------
package sfe_pkg;

  // Framing and escape bytes on the wire
  localparam logic [7:0] STX_BYTE = 8'hF1;
  localparam logic [7:0] CHX_BYTE = 8'hF2;

  // Frame length is received byte 3 plus this offset
  localparam logic [8:0] LEN_OFFSET = 9'd6;

  // Default buffer depth in bytes
  localparam int BUFFER_BYTES_DEF = 128;

  // Input actions
  typedef enum logic [2:0] {
    ACT_LOAD    = 3'd0,
    ACT_START   = 3'd1,
    ACT_EXCHG   = 3'd2,
    ACT_READ    = 3'd3,
    ACT_RELEASE = 3'd4
  } action_t;

endpackage
`default_nettype wire

// ----- sv/spi_escaped_frame_exchanger.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// spi_escaped_frame_exchanger: STX/CHX byte-stuffed full-duplex SPI framer
// Tx/rx buffers in synchronous memories, one transfer a cycle unless stalled.
// ----------------------------------------------------------------------------
// Each accepted transfer carries one action (load, start, exchanged byte, read,
// release) and yields exactly one result transfer through the pipeline and
// output registers. A new transfer is taken every cycle unless both are full
// and the output side stalls; the two registers form a two-entry queue, so
// the input stays ready while one finished result waits. The transmit memory
// is read one entry ahead of the transmit position into a registered read
// port, with write-to-read forwarding, and the current byte is kept in a
// head register; the receive memory is written on each stored byte and
// read through a registered port on the read action. No clearing pass is needed.
module spi_escaped_frame_exchanger #(
  parameter int BUFFER_BYTES = sfe_pkg::BUFFER_BYTES_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [2:0] action,
  input  wire logic [7:0] data_byte,
  input  wire logic [6:0] read_index,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      send_byte,
  output logic            send_valid,
  output logic            frame_done,
  output logic            rx_complete,
  output logic [7:0]      rx_count,
  output logic [7:0]      read_data,
  output logic            load_rejected
);
  import sfe_pkg::*;

  localparam int         AW        = $clog2(BUFFER_BYTES);
  localparam logic [7:0] BUF_LEN   = 8'(BUFFER_BYTES);
  localparam logic [8:0] PAD_LIMIT = 9'(2 * BUFFER_BYTES);
  localparam logic [9:0] BUF_LEN_W = 10'(BUFFER_BYTES);

  // Buffers
  logic [7:0] tx_mem [BUFFER_BYTES];
  logic [7:0] rx_mem [BUFFER_BYTES];
  logic [7:0] tx_rd_q;
  logic [7:0] rx_rd_q;

  // Frame state
  logic [7:0] tx_length, tx_length_next;
  logic [8:0] tx_position, tx_position_next;
  logic [7:0] rx_position, rx_position_next;
  logic [7:0] previous_byte, previous_byte_next;
  logic       rx_done_flag, rx_done_flag_next;
  logic       busy_flag, busy_flag_next;
  logic [7:0] head, head_next;
  logic [7:0] first_byte, first_byte_next;
  logic [7:0] byte3, byte3_next;

  // Memory ports
  logic          tx_we;
  logic [AW-1:0] tx_waddr;
  logic [7:0]    tx_wdata;
  logic [AW-1:0] tx_raddr;
  logic [9:0]    tx_raddr_w;
  logic          rx_we;
  logic [AW-1:0] rx_waddr;
  logic [7:0]    rx_wdata;
  logic [AW-1:0] rx_raddr;

  // Result fields
  logic [7:0] r_send;
  logic       r_valid, r_done, r_rej, r_read;

  // Pipeline register
  logic       p_valid;
  logic [7:0] p_send;
  logic       p_sv, p_done, p_cmpl, p_read, p_rej;
  logic [7:0] p_cnt;

  logic accept, move;
  logic [7:0] rx_v;
  logic [7:0] b3_eff;

  assign move     = p_valid && (!out_valid || out_ready);
  assign in_ready = !p_valid || !out_valid || out_ready;
  assign accept   = in_valid && in_ready;
  assign rx_raddr = AW'(read_index);

  // Decode action, update frame state, drive memory ports
  always_comb begin
    tx_length_next     = tx_length;
    tx_position_next   = tx_position;
    rx_position_next   = rx_position;
    previous_byte_next = previous_byte;
    rx_done_flag_next  = rx_done_flag;
    busy_flag_next     = busy_flag;
    head_next          = head;
    first_byte_next    = first_byte;
    byte3_next         = byte3;
    tx_we    = 1'b0;
    tx_waddr = tx_length[AW-1:0];
    tx_wdata = data_byte;
    rx_we    = 1'b0;
    rx_waddr = rx_position[AW-1:0];
    rx_v     = (previous_byte == CHX_BYTE) ? ~data_byte : data_byte;
    rx_wdata = rx_v;
    b3_eff   = (rx_position == 8'd3) ? rx_v : byte3;
    r_send   = 8'd0;
    r_valid  = 1'b0;
    r_done   = 1'b0;
    r_rej    = 1'b0;
    r_read   = 1'b0;
    if (accept) begin
      case (action_t'(action))
        ACT_LOAD: begin
          if (tx_length < BUF_LEN) begin
            tx_we          = 1'b1;
            tx_length_next = tx_length + 8'd1;
            if (tx_length == 8'd0) first_byte_next = data_byte;
            if ({1'b0, tx_length} == tx_position) head_next = data_byte;
          end else begin
            r_rej = 1'b1;
          end
        end
        ACT_START: begin
          if (!busy_flag && tx_length != 8'd0) begin
            tx_position_next = 9'd0;
            busy_flag_next   = 1'b1;
            head_next        = first_byte;
            r_send           = STX_BYTE;
            r_valid          = 1'b1;
          end
        end
        ACT_EXCHG: begin
          if (busy_flag) begin
            // Deframe the received byte
            if (!rx_done_flag) begin
              if (data_byte == STX_BYTE) begin
                rx_position_next = 8'd0;
              end else if (data_byte != CHX_BYTE &&
                           (rx_position != 8'd0 || previous_byte == STX_BYTE) &&
                           rx_position < BUF_LEN) begin
                rx_we            = 1'b1;
                rx_position_next = rx_position + 8'd1;
                if (rx_position == 8'd3) byte3_next = rx_v;
                if ({1'b0, rx_position_next} == {1'b0, b3_eff} + LEN_OFFSET)
                  rx_done_flag_next = 1'b1;
              end
              previous_byte_next = data_byte;
            end
            // Pick the next byte to send
            if (tx_position < {1'b0, tx_length}) begin
              r_valid = 1'b1;
              if (head == STX_BYTE || head == CHX_BYTE) begin
                tx_we     = 1'b1;
                tx_waddr  = tx_position[AW-1:0];
                tx_wdata  = ~head;
                head_next = ~head;
                if (tx_position == 9'd0) first_byte_next = ~head;
                r_send = CHX_BYTE;
              end else begin
                r_send           = head;
                tx_position_next = tx_position + 9'd1;
                head_next        = tx_rd_q;
              end
            end else if (rx_done_flag_next || rx_position_next == 8'd0 ||
                         tx_position > PAD_LIMIT) begin
              busy_flag_next = 1'b0;
              r_done         = 1'b1;
            end else begin
              r_send  = STX_BYTE;
              r_valid = 1'b1;
              if (tx_position != 9'h1FF) tx_position_next = tx_position + 9'd1;
            end
          end
        end
        ACT_READ: begin
          r_read = ({1'b0, read_index} < BUF_LEN);
        end
        ACT_RELEASE: begin
          if (!busy_flag) begin
            if (rx_done_flag) begin
              rx_done_flag_next = 1'b0;
              rx_position_next  = 8'd0;
            end
            tx_position_next = 9'd0;
            tx_length_next   = 8'd0;
          end
        end
        default: begin
        end
      endcase
    end
    // Look one entry past the transmit position
    tx_raddr_w = {1'b0, tx_position_next} + 10'd1;
    tx_raddr   = (tx_raddr_w < BUF_LEN_W) ? tx_raddr_w[AW-1:0] : '0;
  end

  // Transmit memory: write, registered read with forwarding
  always_ff @(posedge clk) begin
    if (tx_we) tx_mem[tx_waddr] <= tx_wdata;
    if (tx_we && tx_waddr == tx_raddr) tx_rd_q <= tx_wdata;
    else tx_rd_q <= tx_mem[tx_raddr];
  end

  // Receive memory: store deframed bytes, read back by index
  always_ff @(posedge clk) begin
    if (rx_we) rx_mem[rx_waddr] <= rx_wdata;
    if (r_read) rx_rd_q <= rx_mem[rx_raddr];
  end

  // Hold frame state
  always_ff @(posedge clk) begin
    if (rst) begin
      tx_length     <= 8'd0;
      tx_position   <= 9'd0;
      rx_position   <= 8'd0;
      previous_byte <= 8'd0;
      rx_done_flag  <= 1'b0;
      busy_flag     <= 1'b0;
    end else begin
      tx_length     <= tx_length_next;
      tx_position   <= tx_position_next;
      rx_position   <= rx_position_next;
      previous_byte <= previous_byte_next;
      rx_done_flag  <= rx_done_flag_next;
      busy_flag     <= busy_flag_next;
    end
    head       <= head_next;
    first_byte <= first_byte_next;
    byte3      <= byte3_next;
  end

  // Pipeline register: capture the result of each accepted transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else if (accept) begin
      p_valid <= 1'b1;
    end else if (move) begin
      p_valid <= 1'b0;
    end
    if (accept) begin
      p_send <= r_send;
      p_sv   <= r_valid;
      p_done <= r_done;
      p_cmpl <= rx_done_flag_next;
      p_cnt  <= rx_position_next;
      p_read <= r_read;
      p_rej  <= r_rej;
    end
  end

  // Output register: advance when empty or taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (move) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (move) begin
      send_byte     <= p_send;
      send_valid    <= p_sv;
      frame_done    <= p_done;
      rx_complete   <= p_cmpl;
      rx_count      <= p_cnt;
      read_data     <= p_read ? rx_rd_q : 8'd0;
      load_rejected <= p_rej;
    end
  end

endmodule
`default_nettype wire

// ----- verif/spi_escaped_frame_exchanger_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spi_escaped_frame_exchanger_tb: self-checking bench for the SPI framer
// A generator plans whole frames (tx loads, start, STX/CHX-stuffed receive
// bytes, padding to the end of frame, readback, release) against an in-bench
// predictor. A clocked driver plays the planned transfers with random idle
// bursts, and a clocked monitor checks every result in order under random stalls.
// ----------------------------------------------------------------------------
module spi_escaped_frame_exchanger_tb;
  import sfe_pkg::*;

  localparam int BUF          = BUFFER_BYTES_DEF;
  localparam int PAD_LIMIT    = 2 * BUF;
  localparam int RANDOM_ITEMS = 2000;
  localparam int TAIL_ITEMS   = 150;
  localparam int TAIL_CYCLES  = 20;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int MAX_REPORTS  = 10;

  // Action codes the block must ignore
  localparam logic [2:0] ACT_UNUSED_LO = 3'd5;
  localparam logic [2:0] ACT_UNUSED_HI = 3'd7;

  typedef struct packed {
    logic [2:0] act;
    logic [7:0] data;
    logic [6:0] idx;
  } req_t;

  typedef struct packed {
    logic [7:0] send_byte;
    logic       send_valid;
    logic       frame_done;
    logic       rx_complete;
    logic [7:0] rx_count;
    logic [7:0] read_data;
    logic       load_rejected;
  } resp_t;

  typedef struct packed {
    req_t  req;
    resp_t rsp;
  } xfer_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [2:0] action = ACT_LOAD;
  logic [7:0] data_byte = 8'h00;
  logic [6:0] read_index = 7'd0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] send_byte;
  logic       send_valid;
  logic       frame_done;
  logic       rx_complete;
  logic [7:0] rx_count;
  logic [7:0] read_data;
  logic       load_rejected;

  spi_escaped_frame_exchanger #(
    .BUFFER_BYTES(BUF)
  ) i_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .action       (action),
    .data_byte    (data_byte),
    .read_index   (read_index),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .send_byte    (send_byte),
    .send_valid   (send_valid),
    .frame_done   (frame_done),
    .rx_complete  (rx_complete),
    .rx_count     (rx_count),
    .read_data    (read_data),
    .load_rejected(load_rejected)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor state
  bit [7:0] txbuf [BUF];
  bit [7:0] rxbuf [BUF];
  bit       rxbuf_valid [BUF];
  int       rxbuf_valid_cnt = 0;
  int       txbuf_len = 0;
  int       tx_ptr = 0;
  int       rx_ptr = 0;
  bit [7:0] last_wire = 8'h00;
  bit       rx_frame_done = 1'b0;
  bit       engine_busy = 1'b0;
  bit       step_effective;

  // Planned transfers and results owed by the block
  xfer_t pending_xfers [$];
  resp_t expected_results [$];

  int issued_count = 0;
  int effective_count = 0;
  int planned_total = 0;
  int sent_count = 0;
  int checked_count = 0;
  int error_count = 0;
  int frames_done = 0;
  int loads_rejected = 0;
  int readbacks = 0;
  int cycle_count = 0;
  int idle_left = 0;
  int stall_left = 0;
  logic tail_calm;

  assign tail_calm = (planned_total != 0) && (sent_count + TAIL_ITEMS >= planned_total);

  // Advance the framer by one action and return the result it owes
  function automatic resp_t exchanger_predict(req_t r);
    resp_t    o;
    bit [7:0] b;
    bit [7:0] c;
    o = '0;
    b = r.data;
    step_effective = 1'b1;
    case (r.act)
      ACT_LOAD: begin
        if (txbuf_len < BUF) begin
          txbuf[txbuf_len] = b;
          txbuf_len++;
        end else begin
          o.load_rejected = 1'b1;
        end
      end
      ACT_START: begin
        if (!engine_busy && txbuf_len != 0) begin
          tx_ptr = 0;
          engine_busy = 1'b1;
          o.send_byte = STX_BYTE;
          o.send_valid = 1'b1;
        end else begin
          step_effective = 1'b0;
        end
      end
      ACT_EXCHG: begin
        if (!engine_busy) begin
          step_effective = 1'b0;
        end else begin
          // Deframe the received byte unless the frame is already complete
          if (!rx_frame_done) begin
            if (b == STX_BYTE) begin
              rx_ptr = 0;
            end else if (b != CHX_BYTE && (rx_ptr != 0 || last_wire == STX_BYTE)
                         && rx_ptr < BUF) begin
              rxbuf[rx_ptr] = (last_wire == CHX_BYTE) ? ~b : b;
              if (!rxbuf_valid[rx_ptr]) rxbuf_valid_cnt++;
              rxbuf_valid[rx_ptr] = 1'b1;
              rx_ptr++;
              if (rx_ptr == int'(rxbuf[3]) + int'(LEN_OFFSET)) rx_frame_done = 1'b1;
            end
            last_wire = b;
          end
          // Pick the next wire byte: data with escapes, then STX padding
          if (tx_ptr < txbuf_len) begin
            c = txbuf[tx_ptr];
            if (c == STX_BYTE || c == CHX_BYTE) begin
              txbuf[tx_ptr] = ~c;
              o.send_byte = CHX_BYTE;
            end else begin
              o.send_byte = c;
              tx_ptr++;
            end
            o.send_valid = 1'b1;
          end else if (rx_frame_done || rx_ptr == 0 || tx_ptr > PAD_LIMIT) begin
            engine_busy = 1'b0;
            o.frame_done = 1'b1;
          end else begin
            o.send_byte = STX_BYTE;
            o.send_valid = 1'b1;
            if (tx_ptr < 511) tx_ptr++;
          end
        end
      end
      ACT_READ: begin
        o.read_data = rxbuf[r.idx];
      end
      ACT_RELEASE: begin
        if (!engine_busy) begin
          if (rx_frame_done) begin
            rx_frame_done = 1'b0;
            rx_ptr = 0;
          end
          tx_ptr = 0;
          txbuf_len = 0;
        end else begin
          step_effective = 1'b0;
        end
      end
      default: step_effective = 1'b0;
    endcase
    o.rx_complete = rx_frame_done;
    o.rx_count = rx_ptr[7:0];
    return o;
  endfunction

  // Plan one transfer and its expected result
  task automatic issue(logic [2:0] act, logic [7:0] data, logic [6:0] idx);
    xfer_t x;
    x.req = '{act, data, idx};
    x.rsp = exchanger_predict(x.req);
    issued_count++;
    if (step_effective) effective_count++;
    if (x.rsp.frame_done) frames_done++;
    if (x.rsp.load_rejected) loads_rejected++;
    if (act == ACT_READ) readbacks++;
    pending_xfers.push_back(x);
  endtask

  // Bias data toward the framing and escape bytes
  function automatic logic [7:0] stuffing_byte();
    case ($urandom_range(0, 7))
      0: return STX_BYTE;
      1: return CHX_BYTE;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Read back a receive entry that holds data
  task automatic issue_read();
    int i;
    if (rxbuf_valid_cnt == 0) return;
    i = $urandom_range(0, BUF - 1);
    while (!rxbuf_valid[i]) i = (i + 1) % BUF;
    issue(ACT_READ, 8'($urandom_range(0, 255)), 7'(i));
  endtask

  task automatic issue_noise();
    case ($urandom_range(0, 5))
      0: issue(3'($urandom_range(ACT_UNUSED_LO, ACT_UNUSED_HI)),
               8'($urandom_range(0, 255)), 7'($urandom_range(0, 127)));
      1: issue_read();
      2: issue(ACT_START, 8'($urandom_range(0, 255)), 7'($urandom_range(0, 127)));
      3: issue(ACT_RELEASE, 8'($urandom_range(0, 255)), 7'($urandom_range(0, 127)));
      4: issue(ACT_LOAD, stuffing_byte(), 7'($urandom_range(0, 127)));
      default: issue(ACT_EXCHG, 8'($urandom_range(0, 255)), 7'($urandom_range(0, 127)));
    endcase
  endtask

  // Plan one full frame: load, start, exchange until the end, read back
  task automatic random_frame();
    int         sel;
    int         n_tx;
    int         b3;
    int         plen;
    int         pos;
    int         guard;
    logic [7:0] v;
    logic [7:0] wire_bytes [$];
    if ($urandom_range(0, 9) != 0)
      issue(ACT_RELEASE, 8'($urandom_range(0, 255)), 7'($urandom_range(0, 127)));
    sel = $urandom_range(0, 99);
    if (sel < 85) n_tx = $urandom_range(1, 8);
    else if (sel < 95) n_tx = $urandom_range(9, 40);
    else n_tx = $urandom_range(BUF - 8, BUF + 7);
    repeat (n_tx) issue(ACT_LOAD, stuffing_byte(), 7'($urandom_range(0, 127)));
    if ($urandom_range(0, 9) == 0) issue_noise();
    issue(ACT_START, 8'($urandom_range(0, 255)), 7'($urandom_range(0, 127)));

    // Build the receive frame as it appears on the wire
    sel = $urandom_range(0, 99);
    if (sel < 80) b3 = $urandom_range(0, 8);
    else if (sel < 90) b3 = $urandom_range(9, 60);
    else if (sel < 96) b3 = $urandom_range(BUF - 12, BUF - 6);
    else b3 = $urandom_range(BUF - 5, 255);
    plen = (b3 + 6 <= BUF) ? b3 + 6 : BUF + 2;
    repeat ($urandom_range(0, 2)) wire_bytes.push_back(8'($urandom_range(0, 255)));
    wire_bytes.push_back(STX_BYTE);
    for (int i = 0; i < plen; i++) begin
      v = (i == 3) ? 8'(b3) : stuffing_byte();
      if (v == STX_BYTE || v == CHX_BYTE || $urandom_range(0, 19) == 0) begin
        wire_bytes.push_back(CHX_BYTE);
        wire_bytes.push_back(~v);
      end else begin
        wire_bytes.push_back(v);
      end
    end
    // Break a few frames: cut short, or restart in the middle
    sel = $urandom_range(0, 99);
    if (sel < 4) begin
      repeat ($urandom_range(1, wire_bytes.size() - 2)) void'(wire_bytes.pop_back());
    end else if (sel < 8) begin
      wire_bytes.insert($urandom_range(1, wire_bytes.size() - 1), STX_BYTE);
    end

    // Exchange bytes until the block ends the frame
    pos = 0;
    guard = 0;
    while (engine_busy && guard < 4000) begin
      guard++;
      if ($urandom_range(0, 24) == 0) begin
        issue_noise();
      end else begin
        if (pos < wire_bytes.size()) begin
          v = wire_bytes[pos];
          pos++;
        end else begin
          v = 8'($urandom_range(0, 255));
        end
        issue(ACT_EXCHG, v, 7'($urandom_range(0, 127)));
      end
    end

    repeat ($urandom_range(0, 3)) issue_read();
    if ($urandom_range(0, 29) == 0) begin
      for (int i = 0; i < BUF; i++)
        if (rxbuf_valid[i]) issue(ACT_READ, 8'($urandom_range(0, 255)), 7'(i));
    end
  endtask

  task automatic wait_drained();
    do begin
      @(posedge clk);
      #1;
    end while (pending_xfers.size() != 0 || in_valid || expected_results.size() != 0);
  endtask

  task automatic report_error(string msg);
    error_count++;
    if (error_count <= MAX_REPORTS) $display("ERROR: %s", msg);
  endtask

  // Drive planned transfers, with idle bursts outside the tail
  always @(posedge clk) begin : drive_proc
    xfer_t nxt;
    resp_t cur_rsp;
    if (rst) begin
      in_valid <= 1'b0;
      idle_left = 0;
    end else begin
      if (in_valid && in_ready) begin
        expected_results.push_back(cur_rsp);
        sent_count++;
      end
      if (!in_valid || in_ready) begin
        if (idle_left > 0) begin
          idle_left--;
          in_valid <= 1'b0;
        end else if (!tail_calm && $urandom_range(0, 9) == 0) begin
          idle_left = $urandom_range(0, 6);
          in_valid <= 1'b0;
        end else if (pending_xfers.size() != 0) begin
          nxt = pending_xfers.pop_front();
          cur_rsp = nxt.rsp;
          in_valid <= 1'b1;
          action <= nxt.req.act;
          data_byte <= nxt.req.data;
          read_index <= nxt.req.idx;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Check each result transfer against the oldest owed result
  always @(posedge clk) begin : monitor_proc
    resp_t got;
    resp_t want;
    if (rst) begin
      out_ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && out_ready) begin
        got = '{send_byte, send_valid, frame_done, rx_complete, rx_count, read_data,
                load_rejected};
        if (expected_results.size() == 0) begin
          report_error($sformatf("result with nothing expected: %p", got));
        end else begin
          want = expected_results.pop_front();
          if (got !== want)
            report_error($sformatf(
              "result %0d: exp send=%02h/%0b done=%0b cmpl=%0b cnt=%0d rd=%02h rej=%0b | %s",
              checked_count, want.send_byte, want.send_valid, want.frame_done,
              want.rx_complete, want.rx_count, want.read_data, want.load_rejected,
              $sformatf("got send=%02h/%0b done=%0b cmpl=%0b cnt=%0d rd=%02h rej=%0b",
                        got.send_byte, got.send_valid, got.frame_done, got.rx_complete,
                        got.rx_count, got.read_data, got.load_rejected)));
        end
        checked_count++;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (!tail_calm && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(0, 6);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Bound the run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    // Idle-state corners: ignored exchange, start on empty buffer, unknown codes
    issue(ACT_EXCHG, STX_BYTE, 7'd0);
    issue(ACT_START, 8'h00, 7'd127);
    issue(ACT_RELEASE, 8'hFF, 7'd64);
    issue(ACT_UNUSED_HI, 8'hFF, 7'd127);
    issue(ACT_UNUSED_LO, 8'h00, 7'd0);
    // Load extremes and both bytes that need escaping
    issue(ACT_LOAD, 8'h00, 7'd0);
    issue(ACT_LOAD, 8'hFF, 7'd0);
    issue(ACT_LOAD, STX_BYTE, 7'd0);
    issue(ACT_LOAD, CHX_BYTE, 7'd0);
    // Start, then a second start and a release while busy
    issue(ACT_START, 8'h00, 7'd0);
    issue(ACT_START, 8'h00, 7'd0);
    issue(ACT_RELEASE, 8'h00, 7'd0);
    // Six-byte frame with an escaped STX, then one pad and the end of frame
    issue(ACT_EXCHG, STX_BYTE, 7'd0);
    issue(ACT_EXCHG, 8'h00, 7'd0);
    issue(ACT_EXCHG, CHX_BYTE, 7'd0);
    issue(ACT_EXCHG, ~STX_BYTE, 7'd0);
    issue(ACT_EXCHG, 8'hFF, 7'd0);
    issue(ACT_EXCHG, 8'h00, 7'd0);
    issue(ACT_EXCHG, 8'hAA, 7'd0);
    issue(ACT_EXCHG, 8'h55, 7'd0);
    while (engine_busy) issue(ACT_EXCHG, 8'h00, 7'd0);
    issue(ACT_READ, 8'h00, 7'd1);
    issue(ACT_READ, 8'h00, 7'd3);
    issue(ACT_RELEASE, 8'h00, 7'd0);

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Hold off the random part until the directed results are all back
    wait_drained();
    while (effective_count < RANDOM_ITEMS) random_frame();
    planned_total = issued_count;
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (expected_results.size() != 0)
      report_error($sformatf("%0d results never arrived", expected_results.size()));

    $display("Covered %0d transfers and %0d results: %0d frames ended, %0d loads rejected,",
             sent_count, checked_count, frames_done, loads_rejected);
    $display("%0d readbacks, %0d errors", readbacks, error_count);
    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
